// ===== rtl/smac_pkg.sv =====
// Shared types, constants and the bug-class decoder for the shadow memory access checker.
package smac_pkg;

  localparam int ADDR_WIDTH    = 32;
  localparam int SIZE_WIDTH    = 32;
  localparam int GRANULE_SHIFT = 3;
  localparam int SHADOW_AW     = 16;
  localparam int SHADOW_DEPTH  = 1 << SHADOW_AW;
  localparam int ENT_W         = ADDR_WIDTH - GRANULE_SHIFT;
  localparam int CFG_W         = 16;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic [3:0] BUG_UNKNOWN        = 4'd0;
  localparam logic [3:0] BUG_HEAP_OVERFLOW  = 4'd1;
  localparam logic [3:0] BUG_USE_AFTER_FREE = 4'd2;
  localparam logic [3:0] BUG_STACK_UNDER    = 4'd3;
  localparam logic [3:0] BUG_INIT_ORDER     = 4'd4;
  localparam logic [3:0] BUG_STACK_OVER     = 4'd5;
  localparam logic [3:0] BUG_AFTER_RETURN   = 4'd6;
  localparam logic [3:0] BUG_AFTER_POISON   = 4'd7;
  localparam logic [3:0] BUG_CONTAINER      = 4'd8;
  localparam logic [3:0] BUG_AFTER_SCOPE    = 4'd9;
  localparam logic [3:0] BUG_GLOBAL         = 4'd10;
  localparam logic [3:0] BUG_INTRA_OBJECT   = 4'd11;
  localparam logic [3:0] BUG_DYNAMIC_STACK  = 4'd12;

  localparam logic [7:0] MAGIC_HEAP_LEFT    = 8'hfa;
  localparam logic [7:0] MAGIC_HEAP_RIGHT   = 8'hac;
  localparam logic [7:0] MAGIC_FREED        = 8'hfd;
  localparam logic [7:0] MAGIC_STACK_LEFT   = 8'hf1;
  localparam logic [7:0] MAGIC_STACK_MID    = 8'hf2;
  localparam logic [7:0] MAGIC_STACK_RIGHT  = 8'hf3;
  localparam logic [7:0] MAGIC_INIT_ORDER   = 8'hf6;
  localparam logic [7:0] MAGIC_AFTER_RET    = 8'hf5;
  localparam logic [7:0] MAGIC_POISONED     = 8'hf7;
  localparam logic [7:0] MAGIC_CONTAINER    = 8'hfc;
  localparam logic [7:0] MAGIC_AFTER_SCOPE  = 8'hf8;
  localparam logic [7:0] MAGIC_GLOBAL       = 8'hf9;
  localparam logic [7:0] MAGIC_INTRA_OBJECT = 8'hbb;
  localparam logic [7:0] MAGIC_ALLOCA_LEFT  = 8'hca;
  localparam logic [7:0] MAGIC_ALLOCA_RIGHT = 8'hcb;

  typedef struct packed {
    logic                  command;
    logic [ADDR_WIDTH-1:0] access_address;
    logic [SIZE_WIDTH-1:0] access_size;
    logic                  store_access;
    logic [SHADOW_AW-1:0]  shadow_index;
    logic [7:0]            shadow_value;
  } in_item_t;

  typedef struct packed {
    logic                  was_checked;
    logic                  violation;
    logic [ADDR_WIDTH-1:0] first_bad_address;
    logic [3:0]            bug_class;
    logic                  write_echo;
  } out_item_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic                     command;
    logic                     store_access;
    logic                     checked;
    logic [SHADOW_AW-1:0]     beg_entry;
    logic [SHADOW_AW-1:0]     end_entry;
    logic [GRANULE_SHIFT-1:0] lo;
    logic [GRANULE_SHIFT-1:0] hi;
    logic [SHADOW_AW-1:0]     shadow_index;
    logic [7:0]               shadow_value;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } front_out_t;

  typedef struct packed {
    logic take;
    logic clearing;
  } back_ctl_t;

  function automatic logic [3:0] classify(input logic [7:0] v);
    logic [3:0] c;
    case (v)
      MAGIC_HEAP_LEFT, MAGIC_HEAP_RIGHT:     c = BUG_HEAP_OVERFLOW;
      MAGIC_FREED:                           c = BUG_USE_AFTER_FREE;
      MAGIC_STACK_LEFT:                      c = BUG_STACK_UNDER;
      MAGIC_INIT_ORDER:                      c = BUG_INIT_ORDER;
      MAGIC_STACK_MID, MAGIC_STACK_RIGHT:    c = BUG_STACK_OVER;
      MAGIC_AFTER_RET:                       c = BUG_AFTER_RETURN;
      MAGIC_POISONED:                        c = BUG_AFTER_POISON;
      MAGIC_CONTAINER:                       c = BUG_CONTAINER;
      MAGIC_AFTER_SCOPE:                     c = BUG_AFTER_SCOPE;
      MAGIC_GLOBAL:                          c = BUG_GLOBAL;
      MAGIC_INTRA_OBJECT:                    c = BUG_INTRA_OBJECT;
      MAGIC_ALLOCA_LEFT, MAGIC_ALLOCA_RIGHT: c = BUG_DYNAMIC_STACK;
      default:                               c = BUG_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/smac_front.sv =====
// Front end: window check of incoming words and a two-entry job queue.
module smac_front
  import smac_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  in_item_t         in_data,
  input  logic [CFG_W-1:0] first_entry,
  input  logic [CFG_W-1:0] last_entry,
  input  back_ctl_t        back_ctl,
  output front_out_t       front_out
);

  logic [ADDR_WIDTH:0]   last_addr;
  logic [ENT_W-1:0]      beg_full;
  logic [ENT_W-1:0]      end_full;
  logic                  in_window;
  job_t                  job_in;
  job_t                  q_r [2];
  logic                  wp_r, rp_r;
  logic [1:0]            cnt_r;
  logic                  do_push, do_pop;

  always_comb begin
    last_addr = {1'b0, in_data.access_address}
              + {{(ADDR_WIDTH+1-SIZE_WIDTH){1'b0}}, in_data.access_size}
              - {{ADDR_WIDTH{1'b0}}, 1'b1};
    beg_full  = in_data.access_address[ADDR_WIDTH-1:GRANULE_SHIFT];
    end_full  = last_addr[ADDR_WIDTH-1:GRANULE_SHIFT];
    in_window = (in_data.access_size != '0) && !last_addr[ADDR_WIDTH]
              && (beg_full >= {{(ENT_W-CFG_W){1'b0}}, first_entry})
              && (end_full <= {{(ENT_W-CFG_W){1'b0}}, last_entry})
              && (end_full[ENT_W-1:SHADOW_AW] == '0);
    job_in.command      = in_data.command;
    job_in.store_access = in_data.store_access;
    job_in.checked      = in_window;
    job_in.beg_entry    = beg_full[SHADOW_AW-1:0];
    job_in.end_entry    = end_full[SHADOW_AW-1:0];
    job_in.lo           = in_data.access_address[GRANULE_SHIFT-1:0];
    job_in.hi           = last_addr[GRANULE_SHIFT-1:0];
    job_in.shadow_index = in_data.shadow_index;
    job_in.shadow_value = in_data.shadow_value;
  end

  assign full    = (cnt_r == 2'd2) || back_ctl.clearing;
  assign do_push = push && !full;
  assign do_pop  = back_ctl.take && (cnt_r != 2'd0);

  assign front_out = {(cnt_r != 2'd0), q_r[rp_r]};

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/smac_back.sv =====
// Back end: shadow store, granule scan engine and two-entry result queue.
module smac_back
  import smac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  front_out_t front_out,
  output back_ctl_t  back_ctl,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_data
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_EV, S_CLS_RD, S_CLS_EV
  } state_t;

  state_t                state_r, state_nxt;
  logic [SHADOW_AW-1:0]  g_r, g_nxt;
  logic [SHADOW_AW-1:0]  clr_r, clr_nxt;
  job_t                  job_r, job_nxt;
  logic [ADDR_WIDTH-1:0] bad_r, bad_nxt;

  logic [7:0]            mem [SHADOW_DEPTH];
  logic [7:0]            rd_r;
  logic [SHADOW_AW-1:0]  rd_addr;
  logic                  we;
  logic [SHADOW_AW-1:0]  wa;
  logic [7:0]            wd;

  out_item_t             res;
  logic                  res_push;
  out_item_t             oq_r [2];
  logic                  owp_r, orp_r;
  logic [1:0]            ocnt_r;
  logic                  do_pop;

  logic [GRANULE_SHIFT-1:0] lo_cur, hi_cur;
  logic [7:0]               off;
  logic                     bad;
  logic                     partial;

  always_comb begin
    lo_cur  = (g_r == job_r.beg_entry) ? job_r.lo : '0;
    hi_cur  = (g_r == job_r.end_entry) ? job_r.hi : '1;
    partial = (rd_r != 8'd0) && !rd_r[7];
    if (rd_r[7] || (rd_r <= {5'd0, lo_cur})) begin
      off = {5'd0, lo_cur};
    end else begin
      off = rd_r;
    end
    bad = (rd_r != 8'd0) && (off <= {5'd0, hi_cur});
  end

  always_comb begin
    state_nxt         = state_r;
    g_nxt             = g_r;
    clr_nxt           = clr_r;
    job_nxt           = job_r;
    bad_nxt           = bad_r;
    back_ctl.take     = 1'b0;
    back_ctl.clearing = (state_r == S_CLEAR);
    we                = 1'b0;
    wa                = clr_r;
    wd                = 8'd0;
    res_push          = 1'b0;
    res               = '0;
    rd_addr           = (state_r == S_CLS_RD) ? g_r + 1'b1 : g_r;
    unique case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (front_out.valid && (ocnt_r != 2'd2)) begin
          back_ctl.take = 1'b1;
          job_nxt       = front_out.job;
          g_nxt         = front_out.job.beg_entry;
          if (front_out.job.command == CMD_WRITE) begin
            we       = 1'b1;
            wa       = front_out.job.shadow_index;
            wd       = front_out.job.shadow_value;
            res_push = 1'b1;
          end else if (!front_out.job.checked) begin
            res_push       = 1'b1;
            res.write_echo = front_out.job.store_access;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        res.was_checked       = 1'b1;
        res.write_echo        = job_r.store_access;
        res.violation         = bad;
        res.first_bad_address = {{(ADDR_WIDTH-SHADOW_AW-GRANULE_SHIFT){1'b0}}, g_r,
                                 off[GRANULE_SHIFT-1:0]};
        bad_nxt               = res.first_bad_address;
        if (bad) begin
          if (partial && (g_r != '1)) begin
            state_nxt = S_CLS_RD;
          end else begin
            res.bug_class = partial ? BUG_UNKNOWN : classify(rd_r);
            res_push      = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (g_r == job_r.end_entry) begin
          res.first_bad_address = '0;
          res_push              = 1'b1;
          state_nxt             = S_IDLE;
        end else begin
          g_nxt     = g_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_CLS_RD: state_nxt = S_CLS_EV;
      S_CLS_EV: begin
        res.was_checked       = 1'b1;
        res.violation         = 1'b1;
        res.first_bad_address = bad_r;
        res.bug_class         = classify(rd_r);
        res.write_echo        = job_r.store_access;
        res_push              = 1'b1;
        state_nxt             = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    g_r   <= g_nxt;
    job_r <= job_nxt;
    bad_r <= bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[rd_addr];
  end

  // result queue
  assign empty    = (ocnt_r == 2'd0);
  assign do_pop   = pop && !empty;
  assign out_data = oq_r[orp_r];

  always_ff @(posedge clk) begin
    if (res_push) oq_r[owp_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (res_push) owp_r <= !owp_r;
      if (do_pop)   orp_r <= !orp_r;
      ocnt_r <= ocnt_r + {1'b0, res_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/shadow_memory_access_checker_top.sv =====
// A write or an unchecked word gets its result pushed when the back end takes it (S_IDLE);
// a check reads and evaluates each granule in turn (S_RD, S_EV), plus one more read and
// evaluate (S_CLS_RD, S_CLS_EV) when the class comes from the following entry.
// The back end takes a new word only when idle and the result queue has room; the front
// queue holds up to two words. Reset: synchronous active low; then a clearing pass zeros
// the shadow store while full stays high (register writes are still taken).
module shadow_memory_access_checker_top
  import smac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_data,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_FIRST = 1'b0;
  localparam logic REG_LAST  = 1'b1;

  logic [CFG_W-1:0] first_r, last_r;
  front_out_t       front_out;
  back_ctl_t        back_ctl;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      last_r  <= '1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_FIRST) first_r <= pwdata[CFG_W-1:0];
      else                       last_r  <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = {{(32-CFG_W){1'b0}}, (paddr[2] == REG_LAST) ? last_r : first_r};

  smac_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_data     (in_data),
    .first_entry (first_r),
    .last_entry  (last_r),
    .back_ctl    (back_ctl),
    .front_out   (front_out)
  );

  smac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .front_out (front_out),
    .back_ctl  (back_ctl),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the shadow memory access checker: directed table, then random.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import smac_pkg::*;

  localparam int REG_FIRST  = 0;
  localparam int REG_LAST   = 1;
  localparam int IDLE_LIMIT = 400000;
  localparam int PHASE_LEN  = 360;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  shadow_memory_access_checker_top dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]  shadow_copy [SHADOW_DEPTH];
  logic [15:0] win_first = 16'd0;
  logic [15:0] win_last  = 16'hffff;
  out_item_t   pending_results [$];
  stim_row_t   rows [$];
  int          errors = 0;
  int          popped = 0;
  int          idle_cycles = 0;

  localparam logic [7:0] MAGICS [15] = '{
    MAGIC_HEAP_LEFT, MAGIC_HEAP_RIGHT, MAGIC_FREED, MAGIC_STACK_LEFT, MAGIC_STACK_MID,
    MAGIC_STACK_RIGHT, MAGIC_INIT_ORDER, MAGIC_AFTER_RET, MAGIC_POISONED,
    MAGIC_CONTAINER, MAGIC_AFTER_SCOPE, MAGIC_GLOBAL, MAGIC_INTRA_OBJECT,
    MAGIC_ALLOCA_LEFT, MAGIC_ALLOCA_RIGHT};

  function automatic logic [7:0] peek_shadow(longint unsigned e);
    return (e < SHADOW_DEPTH) ? shadow_copy[e] : 8'h00;
  endfunction

  function automatic logic [3:0] bug_of(logic [7:0] v);
    logic [3:0] c;
    case (v)
      MAGIC_HEAP_LEFT, MAGIC_HEAP_RIGHT:     c = BUG_HEAP_OVERFLOW;
      MAGIC_FREED:                           c = BUG_USE_AFTER_FREE;
      MAGIC_STACK_LEFT:                      c = BUG_STACK_UNDER;
      MAGIC_INIT_ORDER:                      c = BUG_INIT_ORDER;
      MAGIC_STACK_MID, MAGIC_STACK_RIGHT:    c = BUG_STACK_OVER;
      MAGIC_AFTER_RET:                       c = BUG_AFTER_RETURN;
      MAGIC_POISONED:                        c = BUG_AFTER_POISON;
      MAGIC_CONTAINER:                       c = BUG_CONTAINER;
      MAGIC_AFTER_SCOPE:                     c = BUG_AFTER_SCOPE;
      MAGIC_GLOBAL:                          c = BUG_GLOBAL;
      MAGIC_INTRA_OBJECT:                    c = BUG_INTRA_OBJECT;
      MAGIC_ALLOCA_LEFT, MAGIC_ALLOCA_RIGHT: c = BUG_DYNAMIC_STACK;
      default:                               c = BUG_UNKNOWN;
    endcase
    return c;
  endfunction

  // Apply one word to the shadow copy and work out the access verdict.
  function automatic out_item_t access_verdict(in_item_t it);
    out_item_t       r;
    longint unsigned addr, size, last_b, beg_e, end_e, lo, hi, off, e;
    logic [7:0]      v;
    r = '0;
    if (it.command == CMD_WRITE) begin
      shadow_copy[it.shadow_index] = it.shadow_value;
      return r;
    end
    r.write_echo = it.store_access;
    addr = it.access_address;
    size = it.access_size;
    if (size == 0) return r;
    last_b = addr + size - 1;
    if (last_b > 64'hffff_ffff) return r;
    beg_e = addr >> GRANULE_SHIFT;
    end_e = last_b >> GRANULE_SHIFT;
    if (beg_e < win_first || end_e > win_last || end_e >= SHADOW_DEPTH) return r;
    r.was_checked = 1'b1;
    for (longint unsigned g = beg_e; g <= end_e; g++) begin
      lo = (g == beg_e) ? (addr & 7) : 0;
      hi = (g == end_e) ? (last_b & 7) : 7;
      v = shadow_copy[g];
      if (v == 0) continue;
      if (v >= 8'h80) off = lo;
      else off = (v > lo) ? v : lo;
      if (off > hi) continue;
      r.violation = 1'b1;
      r.first_bad_address = 32'((g << GRANULE_SHIFT) + off);
      e = g;
      if (peek_shadow(e) == 0 && size > 8) e++;
      if (peek_shadow(e) > 0 && peek_shadow(e) < 8'h80) e++;
      r.bug_class = bug_of(peek_shadow(e));
      return r;
    end
    return r;
  endfunction

  function automatic in_item_t shadow_write(int idx, int val);
    in_item_t it;
    it = '0;
    it.command = CMD_WRITE;
    it.shadow_index = 16'(idx);
    it.shadow_value = 8'(val);
    // noise in the unused fields
    it.access_address = $urandom;
    it.access_size = $urandom;
    it.store_access = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t access_check(logic [31:0] a, logic [31:0] s, logic w);
    in_item_t it;
    it = '0;
    it.command = CMD_CHECK;
    it.access_address = a;
    it.access_size = s;
    it.store_access = w;
    it.shadow_index = 16'($urandom);
    it.shadow_value = 8'($urandom);
    return it;
  endfunction

  function automatic out_item_t verdict(logic c, logic v, logic [31:0] a, logic [3:0] b,
                                       logic w);
    out_item_t r;
    r.was_checked = c;
    r.violation = v;
    r.first_bad_address = a;
    r.bug_class = b;
    r.write_echo = w;
    return r;
  endfunction

  function automatic void add_row(in_item_t it, bit typed = 0, out_item_t want = '0);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    rows.push_back(row);
  endfunction

  function automatic in_item_t random_word();
    int       pick;
    in_item_t it;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) it = shadow_write($urandom_range(0, 255), 0);
      else if (pick < 5) it = shadow_write($urandom_range(0, 255), $urandom_range(1, 7));
      else if (pick < 8) it = shadow_write($urandom_range(0, 255), MAGICS[$urandom_range(0, 14)]);
      else if (pick < 9) it = shadow_write($urandom_range(0, 255), $urandom_range(0, 255));
      else it = shadow_write($urandom_range(0, 65535), $urandom_range(0, 255));
    end else if (pick < 90) begin
      it = access_check($urandom_range(0, 2047), $urandom_range(1, 24), 1'($urandom));
    end else if (pick < 93) begin
      it = access_check($urandom_range(0, 2047), 0, 1'($urandom));
    end else if (pick < 96) begin
      it = access_check($urandom_range(0, 4095), $urandom_range(25, 2048), 1'($urandom));
    end else begin
      it = access_check($urandom, $urandom, 1'($urandom));
    end
    return it;
  endfunction

  task automatic cfg_write(int idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_FIRST) win_first = val[15:0];
    else win_last = val[15:0];
    @(posedge clk);
  endtask

  task automatic send_word(in_item_t it);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    pending_results.push_back(access_verdict(it));
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_word(random_word());
    push <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off to fill the block.
  initial begin
    int        stall;
    out_item_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (popped == 300) stall = 400;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      popped++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: chk %b/%b viol %b/%b addr %h/%h class %0d/%0d wr %b/%b",
                     want.was_checked, out_data.was_checked, want.violation,
                     out_data.violation, want.first_bad_address,
                     out_data.first_bad_address, want.bug_class, out_data.bug_class,
                     want.write_echo, out_data.write_echo);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    out_item_t pred;
    foreach (shadow_copy[i]) shadow_copy[i] = 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(access_check(0, 8, 0), 1, verdict(1, 0, 0, BUG_UNKNOWN, 0));
    add_row(access_check(0, 0, 1), 1, verdict(0, 0, 0, BUG_UNKNOWN, 1));
    add_row(access_check(32'hffff_ffff, 1, 0), 1, verdict(0, 0, 0, BUG_UNKNOWN, 0));
    add_row(access_check(32'hffff_fff0, 32'hffff_ffff, 1), 1,
            verdict(0, 0, 0, BUG_UNKNOWN, 1));
    add_row(shadow_write(1, 4), 1, '0);
    add_row(access_check(8, 8, 1), 1, verdict(1, 1, 12, BUG_UNKNOWN, 1));
    add_row(shadow_write(2, MAGIC_HEAP_LEFT));
    add_row(access_check(8, 16, 0));
    add_row(shadow_write(3, 8'h40));
    add_row(access_check(24, 8, 0));
    add_row(shadow_write(5, MAGIC_STACK_MID));
    add_row(access_check(32, 16, 1));
    add_row(shadow_write(65535, MAGIC_POISONED), 1, '0);
    add_row(access_check(32'h7fff8, 8, 0), 1, verdict(1, 1, 32'h7fff8, BUG_AFTER_POISON, 0));
    add_row(shadow_write(6, 8'hff));
    add_row(access_check(48, 1, 1), 1, verdict(1, 1, 48, BUG_UNKNOWN, 1));
    add_row(shadow_write(7, 3));
    add_row(access_check(61, 2, 0));
    add_row(access_check(0, 32'h80000, 1));
    add_row(access_check(0, 32'h80001, 0), 1, verdict(0, 0, 0, BUG_UNKNOWN, 0));
    add_row(shadow_write(1, 0));

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        pred = access_verdict(rows[i].item);
        // undo the shadow update; send_word applies it again
        if (rows[i].item.command == CMD_WRITE)
          shadow_copy[rows[i].item.shadow_index] = 8'h00;
        if (pred !== rows[i].want) begin
          errors++;
          if (errors <= 10) $display("row %0d: table %h, predictor %h", i, rows[i].want, pred);
        end
      end
      send_word(rows[i].item);
    end
    push <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);

    run_random(PHASE_LEN);
    cfg_write(REG_FIRST, 10);
    cfg_write(REG_LAST, 150);
    run_random(PHASE_LEN);
    cfg_write(REG_FIRST, 0);
    cfg_write(REG_LAST, 0);
    run_random(PHASE_LEN);
    cfg_write(REG_FIRST, 300);
    cfg_write(REG_LAST, 200);
    run_random(PHASE_LEN / 2);
    cfg_write(REG_FIRST, 65535);
    cfg_write(REG_LAST, 65535);
    run_random(PHASE_LEN / 2);
    cfg_write(REG_FIRST, 0);
    cfg_write(REG_LAST, 65535);
    run_random(PHASE_LEN);

    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/smac_pkg.sv
rtl/smac_front.sv
rtl/smac_back.sv
rtl/shadow_memory_access_checker_top.sv
tb/testbench.sv
